/* rtl/core/number_to_english_words_unit_macros.svh */
// Assertion macros shared by the number speller RTL.
`ifndef NUMBER_TO_ENGLISH_WORDS_UNIT_MACROS_SVH
`define NUMBER_TO_ENGLISH_WORDS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition on every clock edge outside reset.
`define NTEW_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define NTEW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define NTEW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NTEW_ASSERT_ALWAYS(label, cond)
`define NTEW_ASSERT_IMP(label, ante, cons)
`define NTEW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/n2ew_pkg.sv */
// Types, constants and the microcode table of the number speller.
package n2ew_pkg;

    localparam int VALUE_W    = 31;
    localparam int WORD_W     = 5;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int SHIFT_W    = 5;
    localparam int PC_W       = 5;

    localparam logic [WORD_W-1:0] WORD_ZERO     = 5'd0;
    localparam logic [WORD_W-1:0] WORD_TEEN0    = 5'd10;
    localparam logic [WORD_W-1:0] WORD_TENS_OFS = 5'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED  = 5'd28;

    localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(VALUE_W - 1);

    // Group indexes: units, thousands, millions, billions
    localparam logic [1:0] GRP_UNITS     = 2'd0;
    localparam logic [1:0] GRP_THOUSANDS = 2'd1;
    localparam logic [1:0] GRP_MILLIONS  = 2'd2;
    localparam logic [1:0] GRP_BILLIONS  = 2'd3;

    // Program addresses
    localparam logic [PC_W-1:0] PC_BILLIONS  = 5'd0;
    localparam logic [PC_W-1:0] PC_MILLIONS  = 5'd6;
    localparam logic [PC_W-1:0] PC_THOUSANDS = 5'd12;
    localparam logic [PC_W-1:0] PC_UNITS     = 5'd18;
    localparam logic [PC_W-1:0] PC_END       = 5'd23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        OP_CHECK,
        OP_HDIG,
        OP_HWORD,
        OP_TENS,
        OP_UNITS,
        OP_SCALE,
        OP_END
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       grp;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    function automatic ctrl_t mk(op_t op, logic [1:0] grp, logic [PC_W-1:0] target);
        ctrl_t c;
        c.op     = op;
        c.grp    = grp;
        c.target = target;
        return c;
    endfunction

    // Microcode: per group skip-if-zero, hundreds digit, Hundred, tens/teen,
    // units, scale word (none for the units group); finish with the end step.
    function automatic ctrl_t rom(logic [PC_W-1:0] pc);
        ctrl_t c;
        unique case (pc)
            5'd0:    c = mk(OP_CHECK, GRP_BILLIONS, PC_MILLIONS);
            5'd1:    c = mk(OP_HDIG,  GRP_BILLIONS, PC_END);
            5'd2:    c = mk(OP_HWORD, GRP_BILLIONS, PC_END);
            5'd3:    c = mk(OP_TENS,  GRP_BILLIONS, PC_END);
            5'd4:    c = mk(OP_UNITS, GRP_BILLIONS, PC_END);
            5'd5:    c = mk(OP_SCALE, GRP_BILLIONS, PC_END);
            5'd6:    c = mk(OP_CHECK, GRP_MILLIONS, PC_THOUSANDS);
            5'd7:    c = mk(OP_HDIG,  GRP_MILLIONS, PC_END);
            5'd8:    c = mk(OP_HWORD, GRP_MILLIONS, PC_END);
            5'd9:    c = mk(OP_TENS,  GRP_MILLIONS, PC_END);
            5'd10:   c = mk(OP_UNITS, GRP_MILLIONS, PC_END);
            5'd11:   c = mk(OP_SCALE, GRP_MILLIONS, PC_END);
            5'd12:   c = mk(OP_CHECK, GRP_THOUSANDS, PC_UNITS);
            5'd13:   c = mk(OP_HDIG,  GRP_THOUSANDS, PC_END);
            5'd14:   c = mk(OP_HWORD, GRP_THOUSANDS, PC_END);
            5'd15:   c = mk(OP_TENS,  GRP_THOUSANDS, PC_END);
            5'd16:   c = mk(OP_UNITS, GRP_THOUSANDS, PC_END);
            5'd17:   c = mk(OP_SCALE, GRP_THOUSANDS, PC_END);
            5'd18:   c = mk(OP_CHECK, GRP_UNITS, PC_END);
            5'd19:   c = mk(OP_HDIG,  GRP_UNITS, PC_END);
            5'd20:   c = mk(OP_HWORD, GRP_UNITS, PC_END);
            5'd21:   c = mk(OP_TENS,  GRP_UNITS, PC_END);
            5'd22:   c = mk(OP_UNITS, GRP_UNITS, PC_END);
            default: c = mk(OP_END,   GRP_UNITS, PC_END);
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/number_to_english_words_unit.sv */
// Number speller: a value below 2^31 in, a run of English word tokens out.
// Operation: bit-serial BCD conversion, then a microcode program of at most 24 steps
//   emits at most one word per step; start is taken only while idle.
// A value is spelled to its final beat before the next is accepted; a zero group
//   skips four or five steps. Busy drops with the final beat.
// Reset: rst_n clears the sequencer, converter control and output strobe; no beat can stall.
`include "number_to_english_words_unit_macros.svh"

module number_to_english_words_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [n2ew_pkg::VALUE_W-1:0]  value,
    output logic                          busy,
    output logic                          strobe,
    output logic [n2ew_pkg::WORD_W-1:0]   word,
    output logic                          last
);
    import n2ew_pkg::*;

    state_t              state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [WORD_W-1:0]   pend_code_reg, pend_code_next;
    logic                strobe_reg, strobe_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                conv_done;
    logic [BCD_W-1:0]    digits;
    ctrl_t               ctrl;
    logic [11:0]         grp_bcd;
    logic [3:0]          hund, tens, units;
    logic                grp_zero;
    logic                tok_valid;
    logic [WORD_W-1:0]   tok_code;

    assign accept = start && (state_reg == ST_IDLE);

    n2ew_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .value  (value),
        .done   (conv_done),
        .digits (digits)
    );

    // Fetch the control word for the current step
    assign ctrl = rom(pc_reg);

    // Select the digits of the addressed group: three, or one for billions
    always_comb
    begin
        unique case (ctrl.grp)
            GRP_UNITS:     grp_bcd = digits[11:0];
            GRP_THOUSANDS: grp_bcd = digits[23:12];
            GRP_MILLIONS:  grp_bcd = digits[35:24];
            default:       grp_bcd = {8'd0, digits[39:36]};
        endcase
    end

    assign hund     = grp_bcd[11:8];
    assign tens     = grp_bcd[7:4];
    assign units    = grp_bcd[3:0];
    assign grp_zero = (grp_bcd == 12'd0);

    // Decode the token that this step produces, if any
    always_comb
    begin
        tok_valid = 1'b0;
        tok_code  = WORD_ZERO;
        unique case (ctrl.op)
            OP_HDIG:
            begin
                tok_valid = (hund != 4'd0);
                tok_code  = {1'b0, hund};
            end
            OP_HWORD:
            begin
                tok_valid = (hund != 4'd0);
                tok_code  = WORD_HUNDRED;
            end
            OP_TENS:
            begin
                if (tens == 4'd1)
                begin
                    tok_valid = 1'b1;
                    tok_code  = WORD_TEEN0 + {1'b0, units};
                end
                else if (tens != 4'd0)
                begin
                    tok_valid = 1'b1;
                    tok_code  = WORD_TENS_OFS + {1'b0, tens};
                end
            end
            OP_UNITS:
            begin
                tok_valid = (tens != 4'd1) && (units != 4'd0);
                tok_code  = {1'b0, units};
            end
            OP_SCALE:
            begin
                tok_valid = 1'b1;
                tok_code  = WORD_HUNDRED + {3'd0, ctrl.grp};
            end
            default:
            begin
                tok_valid = 1'b0;
                tok_code  = WORD_ZERO;
            end
        endcase
    end

    // Sequence conversion and program; hold one token back to mark the last
    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        strobe_next     = 1'b0;
        word_next       = word_reg;
        last_next       = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                pc_next         = PC_BILLIONS;
                pend_valid_next = 1'b0;
                if (conv_done)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (ctrl.op == OP_END)
                begin
                    strobe_next = 1'b1;
                    word_next   = pend_valid_reg ? pend_code_reg : WORD_ZERO;
                    last_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    if (ctrl.op == OP_CHECK && grp_zero)
                        pc_next = ctrl.target;
                    else
                        pc_next = pc_reg + 1'b1;
                    if (tok_valid)
                    begin
                        strobe_next     = pend_valid_reg;
                        word_next       = pend_code_reg;
                        last_next       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_code_next  = tok_code;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        word_reg      <= word_next;
        last_reg      <= last_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign word   = word_reg;
    assign last   = last_reg;

    `NTEW_ASSERT_NEXT(a_accept_busy, accept, busy)
    `NTEW_ASSERT_IMP(a_last_idle, strobe && last, !busy)
    `NTEW_ASSERT_IMP(a_mid_busy, strobe && !last, state_reg == ST_RUN)
    `NTEW_ASSERT_ALWAYS(a_pc_range, (state_reg != ST_RUN) || (pc_reg <= PC_END))

endmodule

/* rtl/core/n2ew_bcd.sv */
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module n2ew_bcd (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [n2ew_pkg::VALUE_W-1:0] value,
    output logic                       done,
    output logic [n2ew_pkg::BCD_W-1:0] digits
);
    import n2ew_pkg::*;

    logic                 busy_reg, busy_next;
    logic [SHIFT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;

    // Add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Load on start, then shift one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = value;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_SHIFT)
                busy_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done   = busy_reg && (cnt_reg == LAST_SHIFT);
    assign digits = bcd_reg;

endmodule

/* bench/tb.sv */
// Testbench for the number speller: directed and random values, checked word by word.
module tb;
    import n2ew_pkg::*;

    localparam logic [WORD_W-1:0] SCALE_THOUSAND = 5'd29;
    localparam logic [WORD_W-1:0] SCALE_MILLION  = 5'd30;
    localparam logic [WORD_W-1:0] SCALE_BILLION  = 5'd31;
    localparam logic [VALUE_W-1:0] VALUE_MAX     = 31'h7fff_ffff;
    localparam int TEEN_LIMIT    = 20;
    localparam int DRAIN_CYCLES  = 64;
    localparam int QUIET_LIMIT   = 2000;
    localparam int IDLE_PERCENT  = 14;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } token_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic [VALUE_W-1:0]  value;
    logic                busy;
    logic                strobe;
    logic [WORD_W-1:0]   word;
    logic                last;

    token_t pending_words[$];
    int     mismatches = 0;
    int     quiet_cycles = 0;

    number_to_english_words_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .busy   (busy),
        .strobe (strobe),
        .word   (word),
        .last   (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Spell one value and queue its words, last flag on the final one
    function automatic void spell_value(input logic [VALUE_W-1:0] v);
        logic [WORD_W-1:0] words[$];
        logic [WORD_W-1:0] scale_word[4];
        int                grp[4];
        int                n;
        int                h;
        int                r;
        n = int'(v);
        grp[3] = n / 1000000000;
        grp[2] = (n / 1000000) % 1000;
        grp[1] = (n / 1000) % 1000;
        grp[0] = n % 1000;
        scale_word[3] = SCALE_BILLION;
        scale_word[2] = SCALE_MILLION;
        scale_word[1] = SCALE_THOUSAND;
        scale_word[0] = WORD_ZERO;
        if (n == 0)
            words.push_back(WORD_ZERO);
        for (int i = 3; i >= 0; i--)
        begin
            // Skip a zero group along with its scale word
            if (grp[i] != 0)
            begin
                h = grp[i] / 100;
                r = grp[i] % 100;
                if (h != 0)
                begin
                    words.push_back(WORD_W'(h));
                    words.push_back(WORD_HUNDRED);
                end
                if (r != 0 && r < TEEN_LIMIT)
                    words.push_back(WORD_W'(r));
                else if (r != 0)
                begin
                    words.push_back(WORD_TENS_OFS + WORD_W'(r / 10));
                    if (r % 10 != 0)
                        words.push_back(WORD_W'(r % 10));
                end
                if (i > 0)
                    words.push_back(scale_word[i]);
            end
        end
        for (int k = 0; k < words.size(); k++)
            pending_words.push_back(token_t'{words[k], k == words.size() - 1});
    endfunction

    // Draw a value: full range, small, group-shaped or near a scale boundary
    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned v;
        longint unsigned scale;
        case ($urandom_range(0, 3))
            0: v = $urandom & 32'h7fff_ffff;
            1: v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 999);
            2:
            begin
                v = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++)
                    v = v * 1000 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 999));
                if (v > VALUE_MAX)
                    v = v - 64'd1000000000;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: scale = 64'd1000;
                    1: scale = 64'd1000000;
                    default: scale = 64'd1000000000;
                endcase
                v = scale * $urandom_range(1, 2) + $urandom_range(0, 20);
                if ($urandom_range(0, 1) == 1)
                    v = v - 10;
                if (v > VALUE_MAX)
                    v = VALUE_MAX;
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // Offer one value, hold start until the unit is idle again, then predict its words
    task automatic send_value(input logic [VALUE_W-1:0] v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        spell_value(v);
    endtask

    // Drop start for a while
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        value <= random_value();
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < IDLE_PERCENT)
            hold_off($urandom_range(1, 70));
    endtask

    // Extremes, zero groups, teens, every tens word and the longest spelling
    task automatic test_directed();
        logic [VALUE_W-1:0] cases[$];
        cases = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd13, 31'd19, 31'd20, 31'd21,
                  31'd99, 31'd100, 31'd101, 31'd110, 31'd999, 31'd1000, 31'd1001,
                  31'd50070, 31'd1000000, 31'd1000010, 31'd1000000000,
                  31'd1002003004, 31'd1234567891, 31'd1777777777, 31'd2000000000,
                  VALUE_MAX};
        foreach (cases[i])
        begin
            send_value(cases[i]);
            maybe_idle();
        end
    endtask

    // Pause the sender until every word in flight has come back
    task automatic test_drain_pause();
        for (int i = 0; i < 12; i++)
        begin
            send_value(random_value());
            if (i == 5)
            begin
                start <= 1'b0;
                while (pending_words.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    // Keep start high with no gaps at all
    task automatic test_back_to_back();
        repeat (40) send_value(random_value());
    endtask

    task automatic test_random();
        repeat (380)
        begin
            send_value(random_value());
            maybe_idle();
        end
    endtask

    // Compare each word beat with the oldest expected word
    always @(posedge clk)
    begin : check_words
        token_t exp_tok;
        if (rst_n && strobe === 1'b1)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual word %0d last %0b",
                         $time, word, last);
                mismatches++;
            end
            else
            begin
                exp_tok = pending_words.pop_front();
                if (word !== exp_tok.word)
                begin
                    $display("%0t: word expected %0d actual %0d", $time, exp_tok.word, word);
                    mismatches++;
                end
                if (last !== exp_tok.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, exp_tok.last, last);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles with no beat in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || strobe === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_back_to_back();
        test_random();

        // Drain the remaining words, then watch for strays
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
